[sv/stwl_pkg.sv]
// ============================================================================
// stwl_pkg
// Shared types and constants for the static trie word lookup block.
// ============================================================================
package stwl_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CELL_W      = 29;

    // Request kinds carried in the action field.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result codes.
    localparam logic [1:0] RES_WORD   = 2'd0;
    localparam logic [1:0] RES_PREFIX = 2'd1;
    localparam logic [1:0] RES_ABSENT = 2'd2;

    // Walker states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } stwl_state_t;

    // Request payload as seen by the walker.
    typedef struct packed {
        logic               action;
        logic [11:0]        cell_index;
        logic [7:0]         cell_char;
        logic signed [12:0] cell_child;
        logic [7:0]         cell_siblings_after;
        logic [7:0]         query_char;
    } stwl_req_t;

    // Write port of the cell memory.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } stwl_wr_t;

    // Result handed from the walker to the output register.
    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } stwl_res_t;

endpackage

[sv/stwl_if.sv]
// ============================================================================
// stwl_if
// Valid/ready channels for requests and results of the trie lookup.
// ============================================================================
interface stwl_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [11:0]        cell_index;
    logic [7:0]         cell_char;
    logic signed [12:0] cell_child;
    logic [7:0]         cell_siblings_after;
    logic [7:0]         query_char;

    modport source (
        output valid, action, cell_index, cell_char, cell_child,
               cell_siblings_after, query_char,
        input  ready
    );

    modport sink (
        input  valid, action, cell_index, cell_char, cell_child,
               cell_siblings_after, query_char,
        output ready
    );
endinterface

interface stwl_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] lookup_result;

    modport source (
        output valid, lookup_result,
        input  ready
    );

    modport sink (
        input  valid, lookup_result,
        output ready
    );
endinterface

[sv/stwl_cell_ram.sv]
// ============================================================================
// stwl_cell_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module stwl_cell_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 29
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/stwl_walker.sv]
// ============================================================================
// stwl_walker
// Request decode and sibling-run scanner that walks the trie in memory.
// ============================================================================
module stwl_walker
    import stwl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  stwl_req_t         req,
    output stwl_wr_t          wr,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [CELL_W-1:0] rd_data,
    input  logic              slot_free,
    output stwl_res_t         res
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    stwl_state_t       state_reg,  state_next;
    logic [ADDR_W-1:0] ptr_reg,    ptr_next;
    logic [ADDR_W-1:0] cur_reg,    cur_next;
    logic              miss_reg,   miss_next;
    logic [7:0]        target_reg, target_next;
    logic              end_reg,    end_next;
    logic [1:0]        code_reg,   code_next;

    // Fields of the cell that the memory returns this cycle.
    logic [7:0]  cell_ch;
    logic [12:0] cell_kid;
    logic [7:0]  cell_sib;
    logic [31:0] kid_ext;
    logic [31:0] idx_ext;
    logic        kid_none;

    assign cell_ch  = rd_data[7:0];
    assign cell_kid = rd_data[20:8];
    assign cell_sib = rd_data[28:21];
    assign kid_ext  = 32'(cell_kid);
    assign idx_ext  = 32'(req.cell_index);
    assign kid_none = cell_kid[12] || (kid_ext >= 32'(TABLE_DEPTH));

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            cur_reg   <= '0;
            miss_reg  <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cur_reg   <= cur_next;
            miss_reg  <= miss_next;
            end_reg   <= end_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        code_reg   <= code_next;
    end

    // Next state, memory access and result.
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        cur_next    = cur_reg;
        miss_next   = miss_reg;
        target_next = target_reg;
        end_next    = end_reg;
        code_next   = code_reg;
        req_ready   = 1'b0;
        wr.en       = 1'b0;
        wr.addr     = idx_ext[ADDR_W-1:0];
        wr.data     = {req.cell_siblings_after, req.cell_child, req.cell_char};
        res.valid   = 1'b0;
        res.code    = code_reg;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req.action == ACT_WRITE)
                    begin
                        // Writes beyond the table are dropped.
                        wr.en = (idx_ext < 32'(TABLE_DEPTH));
                    end
                    else if (req.query_char != 8'd0)
                    begin
                        // Characters after a miss are ignored.
                        if (!miss_reg)
                        begin
                            ptr_next    = cur_reg;
                            target_next = req.query_char;
                            end_next    = 1'b0;
                            state_next  = ST_SCAN;
                        end
                    end
                    else if (miss_reg)
                    begin
                        code_next  = RES_ABSENT;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // End of word: look for the terminator cell.
                        ptr_next    = cur_reg;
                        target_next = 8'd0;
                        end_next    = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cell_ch == target_reg)
                begin
                    if (end_reg)
                    begin
                        code_next  = RES_WORD;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (kid_none)
                        begin
                            miss_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = kid_ext[ADDR_W-1:0];
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if ((cell_sib == 8'd0) || (ptr_reg == LAST_ADDR))
                begin
                    // Run exhausted or cut off at the end of the table.
                    if (end_reg)
                    begin
                        code_next  = RES_PREFIX;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        miss_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end

            ST_DONE:
            begin
                res.valid = slot_free;
                if (slot_free)
                begin
                    cur_next   = '0;
                    miss_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The memory always reads the cell the scan looks at next cycle.
        rd_addr = ptr_next;
    end

endmodule

[sv/static_trie_word_lookup_top.sv]
// ============================================================================
// static_trie_word_lookup_top
// Trie dictionary held in on-chip memory, checked one character at a time.
// ============================================================================
// Requests arrive on req. A request with action 0 writes one table cell. A
// request with action 1 feeds one character of a word, whose sibling run
// is then scanned cell by cell while further requests wait, since the cell
// memory gives one read a cycle. A zero character ends the word: unless a
// character missed, the terminator is searched in the same way, and the
// result goes through the done state and the output register to rsp (0
// word, 1 prefix only, 2 absent). The walk then returns to the root cell.
// A finished result sits in the output register while rsp is stalled, and
// further writes and characters are taken meanwhile; only the next word end
// waits for that register to drain.
// Reset clears the walk position and the miss flag and empties the output
// register. The cell memory is not cleared: every cell that a query may
// reach has to be written first.
// ============================================================================
module static_trie_word_lookup_top
    import stwl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    stwl_req_if.sink   req,
    stwl_rsp_if.source rsp
);

    stwl_req_t         req_pl;
    stwl_wr_t          wr;
    stwl_res_t         res;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic              slot_free;
    logic              out_valid_reg;
    logic [1:0]        result_reg;

    assign req_pl.action              = req.action;
    assign req_pl.cell_index          = req.cell_index;
    assign req_pl.cell_char           = req.cell_char;
    assign req_pl.cell_child          = req.cell_child;
    assign req_pl.cell_siblings_after = req.cell_siblings_after;
    assign req_pl.query_char          = req.query_char;

    // Walker and cell memory.
    stwl_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req_pl),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .slot_free (slot_free),
        .res       (res)
    );

    stwl_cell_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (CELL_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register decouples the result from the receiver.
    assign slot_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            result_reg <= res.code;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.lookup_result = result_reg;

endmodule

[sv/stwl_checker.sv]
// ============================================================================
// stwl_checker
// Port-level checks on the trie lookup, bound to the top level.
// ============================================================================
module stwl_checker
    import stwl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       req_action,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] lookup_result
);

    // A stalled result stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(lookup_result))
        else $error("result changed while stalled");

    // Only the three defined codes are ever delivered.
    a_rsp_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (lookup_result == RES_WORD || lookup_result == RES_PREFIX
                       || lookup_result == RES_ABSENT))
        else $error("undefined result code");

    // A cell write never causes a result of its own.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == ACT_WRITE) && !rsp_valid
        |=> !rsp_valid)
        else $error("result appeared after a cell write");

endmodule

bind static_trie_word_lookup_top stwl_checker u_stwl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_action    (req.action),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .lookup_result (rsp.lookup_result)
);
